/* design/pat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_pkg
// shared codes, defaults and controller/datapath interface types
// ----------------------------------------------------------------------------
package pat_pkg;

    localparam int SLOTS_DEF       = 8;
    localparam int TOK_LIMIT_DEF   = 8;
    localparam int MAX_RESULTS     = 8;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

    // request types
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_RESP   = 2'd3;

    // response status codes
    localparam logic [2:0] ST_SUCCESS   = 3'd0;
    localparam logic [2:0] ST_ERR_CODE  = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_ERR_PLAIN = 3'd3;

    // result kinds
    typedef logic [3:0] t_kind;
    localparam t_kind K_ADDED     = 4'd0;
    localparam t_kind K_FULL      = 4'd1;
    localparam t_kind K_REMOVED   = 4'd2;
    localparam t_kind K_TIMEOUT   = 4'd3;
    localparam t_kind K_SUCCESS   = 4'd4;
    localparam t_kind K_ERROR     = 4'd5;
    localparam t_kind K_BADSTATUS = 4'd6;
    localparam t_kind K_NOMATCH   = 4'd7;
    localparam t_kind K_MALFORMED = 4'd8;

    // where a result's slot number comes from
    typedef logic [1:0] t_slot_src;
    localparam t_slot_src SRC_IDX  = 2'd0;
    localparam t_slot_src SRC_SEL  = 2'd1;
    localparam t_slot_src SRC_ZERO = 2'd2;

    typedef struct packed {
        logic      load_req;
        logic      clr_idx;
        logic      inc_idx;
        logic      rd;
        logic      wr_add;
        logic      wr_dec;
        logic      free;
        logic      free_at_sel;
        logic      push;
        t_kind     push_kind;
        t_slot_src push_src;
        logic      flush;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] resp_status;
        logic       sel_ok;
        logic       cur_free;
        logic       rd_busy;
        logic       expire;
        logic       notify;
        logic       match;
        logic       idx_last;
        logic       res_room;
    } t_stat;

endpackage

/* design/pat_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_ctrl
// sequencer: decodes a request and walks the slot table
// ----------------------------------------------------------------------------
module pat_ctrl
    import pat_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_ADD    = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_EVAL   = 3'd4;
    localparam logic [2:0] S_FLUSH  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.push_src = SRC_IDX;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load_req = 1'b1;
                    o_cmd.clr_idx  = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.req_type)
                    REQ_ADD: n_state = S_ADD;
                    REQ_REMOVE: begin
                        if (i_stat.sel_ok) begin
                            o_cmd.free        = 1'b1;
                            o_cmd.free_at_sel = 1'b1;
                            o_cmd.push        = 1'b1;
                            o_cmd.push_kind   = K_REMOVED;
                            o_cmd.push_src    = SRC_SEL;
                        end
                        n_state = S_FLUSH;
                    end
                    REQ_TICK: n_state = S_READ;
                    default: begin
                        // malformed document: nothing scanned
                        if (i_stat.resp_status > ST_ERR_PLAIN) begin
                            o_cmd.push      = 1'b1;
                            o_cmd.push_kind = K_MALFORMED;
                            o_cmd.push_src  = SRC_ZERO;
                            n_state         = S_FLUSH;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                endcase
            end
            S_ADD: begin
                if (i_stat.cur_free) begin
                    o_cmd.wr_add    = 1'b1;
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = K_ADDED;
                    n_state         = S_FLUSH;
                end else if (i_stat.idx_last) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = K_FULL;
                    o_cmd.push_src  = SRC_ZERO;
                    n_state         = S_FLUSH;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                if (i_stat.req_type == REQ_TICK) begin
                    if (i_stat.rd_busy) begin
                        if (i_stat.expire) begin
                            o_cmd.free = 1'b1;
                            if (i_stat.notify && i_stat.res_room) begin
                                o_cmd.push      = 1'b1;
                                o_cmd.push_kind = K_TIMEOUT;
                            end
                        end else begin
                            o_cmd.wr_dec = 1'b1;
                        end
                    end
                    if (i_stat.idx_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_cmd.inc_idx = 1'b1;
                        n_state       = S_READ;
                    end
                end else begin
                    if (i_stat.rd_busy && i_stat.match) begin
                        o_cmd.free = 1'b1;
                        o_cmd.push = 1'b1;
                        case (i_stat.resp_status)
                            ST_SUCCESS:  o_cmd.push_kind = K_SUCCESS;
                            ST_ERR_CODE: o_cmd.push_kind = K_ERROR;
                            ST_INVALID:  o_cmd.push_kind = K_BADSTATUS;
                            default:     o_cmd.push_kind = K_MALFORMED;
                        endcase
                        n_state = S_FLUSH;
                    end else if (i_stat.idx_last) begin
                        o_cmd.push      = 1'b1;
                        o_cmd.push_kind = K_NOMATCH;
                        o_cmd.push_src  = SRC_ZERO;
                        n_state         = S_FLUSH;
                    end else begin
                        o_cmd.inc_idx = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* design/pat_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_dp
// slot table, request registers, match logic and result register
// ----------------------------------------------------------------------------
module pat_dp
    import pat_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TOK_LIMIT = TOK_LIMIT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [1:0]         i_req_type,
    input  logic [63:0]        i_token,
    input  logic [3:0]         i_tok_count,
    input  logic               i_want_notify,
    input  logic [31:0]        i_timeout_ticks,
    input  logic [2:0]         i_slot_sel,
    input  logic [2:0]         i_resp_status,
    input  logic signed [31:0] i_resp_code,
    output logic               o_valid,
    output logic [3:0]         o_kind,
    output logic [2:0]         o_slot,
    output logic signed [31:0] o_ack_code,
    output logic               o_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TB    = TOK_LIMIT - 1;
    localparam int TOK_W = TB * 8;
    localparam int LEN_W = $clog2(TOK_LIMIT);
    localparam int ENT_W = TOK_W + LEN_W + 32 + 1;

    // latched request
    logic [1:0]         r_type;
    logic [63:0]        r_token;
    logic [3:0]         r_len;
    logic               r_notify;
    logic [31:0]        r_ticks;
    logic [2:0]         r_sel;
    logic [2:0]         r_status;
    logic signed [31:0] r_code;

    logic [IDX_W-1:0]   r_idx;
    logic [SLOTS-1:0]   r_busy;
    logic [CNT_W-1:0]   r_cnt;

    // slot memory: {token, len, remaining, notify}
    logic [ENT_W-1:0]   r_mem [SLOTS];
    logic [ENT_W-1:0]   r_rd_data;
    logic               r_rd_busy;

    logic               r_pend_valid;
    t_kind              r_pend_kind;
    logic [2:0]         r_pend_slot;
    logic signed [31:0] r_pend_code;

    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [2:0]         r_out_slot;
    logic signed [31:0] r_out_code;
    logic               r_out_last;

    logic [TOK_W-1:0]   rd_tok;
    logic [LEN_W-1:0]   rd_len;
    logic [31:0]        rd_rem;
    logic               rd_notify;
    logic [TOK_W-1:0]   add_tok;
    logic [LEN_W-1:0]   add_len;
    logic               match;
    logic               run;
    logic [IDX_W-1:0]   free_idx;
    logic [2:0]         push_slot;

    assign rd_tok    = r_rd_data[ENT_W-1 -: TOK_W];
    assign rd_len    = r_rd_data[33 +: LEN_W];
    assign rd_rem    = r_rd_data[32:1];
    assign rd_notify = r_rd_data[0];

    // stored length is capped at TOK_LIMIT-1 bytes
    assign add_len = (r_len > 4'(TB)) ? LEN_W'(TB) : LEN_W'(r_len);

    always_comb begin
        add_tok = '0;
        for (int j = 0; j < TB; j++) begin
            if (LEN_W'(j) < add_len) begin
                add_tok[8*j +: 8] = r_token[8*j +: 8];
            end
        end
    end

    // prefix compare over the stored length, stopping at the first zero byte of the stored token
    always_comb begin
        match = 1'b1;
        run   = 1'b1;
        for (int j = 0; j < TB; j++) begin
            run = run && (LEN_W'(j) < rd_len) && (rd_tok[8*j +: 8] != 8'h00);
            if (run && (rd_tok[8*j +: 8] != r_token[8*j +: 8])) begin
                match = 1'b0;
            end
        end
    end

    assign free_idx = i_cmd.free_at_sel ? IDX_W'(r_sel) : r_idx;

    always_comb begin
        case (i_cmd.push_src)
            SRC_IDX: push_slot = 3'(r_idx);
            SRC_SEL: push_slot = r_sel;
            default: push_slot = 3'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_type   <= i_req_type;
            r_token  <= i_token;
            r_len    <= i_tok_count;
            r_notify <= i_want_notify;
            r_ticks  <= i_timeout_ticks;
            r_sel    <= i_slot_sel;
            r_status <= i_resp_status;
            r_code   <= i_resp_code;
        end
        if (i_cmd.clr_idx) begin
            r_idx <= '0;
        end else if (i_cmd.inc_idx) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_add) begin
            r_mem[r_idx] <= {add_tok, add_len, r_ticks, r_notify};
        end else if (i_cmd.wr_dec) begin
            r_mem[r_idx] <= {rd_tok, rd_len, rd_rem - 32'd1, rd_notify};
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_idx];
            r_rd_busy <= r_busy[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.wr_add) begin
                r_busy[r_idx] <= 1'b1;
            end else if (i_cmd.free) begin
                r_busy[free_idx] <= 1'b0;
            end
            if (i_cmd.load_req) begin
                r_cnt <= '0;
            end else if (i_cmd.push) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.push) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            r_out_valid <= (i_cmd.push || i_cmd.flush) && r_pend_valid;
        end
    end

    // one result held back so the final one can be marked
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_pend_kind <= i_cmd.push_kind;
            r_pend_slot <= push_slot;
            r_pend_code <= (i_cmd.push_kind == K_ERROR) ? r_code : 32'sd0;
        end
        if (i_cmd.push || i_cmd.flush) begin
            r_out_kind <= r_pend_kind;
            r_out_slot <= r_pend_slot;
            r_out_code <= r_pend_code;
            r_out_last <= i_cmd.flush;
        end
    end

    assign o_stat.req_type    = r_type;
    assign o_stat.resp_status = r_status;
    assign o_stat.sel_ok      = ({4'd0, r_sel} < 7'(SLOTS));
    assign o_stat.cur_free    = !r_busy[r_idx];
    assign o_stat.rd_busy     = r_rd_busy;
    assign o_stat.expire      = (rd_rem <= 32'd1);
    assign o_stat.notify      = rd_notify;
    assign o_stat.match       = match;
    assign o_stat.idx_last    = (r_idx == IDX_W'(SLOTS - 1));
    assign o_stat.res_room    = (r_cnt < CNT_W'(MAX_RESULTS));

    assign o_valid    = r_out_valid;
    assign o_kind     = r_out_kind;
    assign o_slot     = r_out_slot;
    assign o_ack_code = r_out_code;
    assign o_last     = r_out_last;

endmodule

/* design/pending_ack_table_with_timeout.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_ack_table_with_timeout
// table of requests awaiting acknowledgment, with tick-driven expiry
// ----------------------------------------------------------------------------
// one request at a time; busy falls as the final result, if any, goes out, so the
// next request can be taken at the edge that ends that result's cycle
// remove and malformed response go from decode to flush; add searches for a free
// slot; response reads and compares slots to a match, tick reads and ages every slot
// results appear on o_valid one cycle each, final one flagged by o_last
// the receiver cannot stall; synchronous reset empties the table at once (busy bits)

module pending_ack_table_with_timeout
    import pat_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TOK_LIMIT = TOK_LIMIT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic [63:0]        i_token,
    input  logic [3:0]         i_tok_count,
    input  logic               i_want_notify,
    input  logic [31:0]        i_timeout_ticks,
    input  logic [2:0]         i_slot_sel,
    input  logic [2:0]         i_resp_status,
    input  logic signed [31:0] i_resp_code,
    output logic               o_valid,
    output logic [3:0]         o_kind,
    output logic [2:0]         o_slot,
    output logic signed [31:0] o_ack_code,
    output logic               o_last
);

    // controller drives commands, datapath returns slot status
    t_cmd  cmd;
    t_stat stat;

    pat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // slot storage, token compare and the held-back result register
    pat_dp #(
        .SLOTS     (SLOTS),
        .TOK_LIMIT (TOK_LIMIT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_req_type      (i_req_type),
        .i_token         (i_token),
        .i_tok_count     (i_tok_count),
        .i_want_notify   (i_want_notify),
        .i_timeout_ticks (i_timeout_ticks),
        .i_slot_sel      (i_slot_sel),
        .i_resp_status   (i_resp_status),
        .i_resp_code     (i_resp_code),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_slot          (o_slot),
        .o_ack_code      (o_ack_code),
        .o_last          (o_last)
    );

endmodule
